FILE: design/va_pkg.sv
// ----------------------------------------------------------------------------
// va_pkg
// Shared widths, opcodes, status codes, beat types and arithmetic helpers for
// the fixed-point 3-D vector ALU.
// ----------------------------------------------------------------------------
package va_pkg;

  // Word and fraction widths of the Q16.16 format.
  localparam int W  = 32;
  localparam int F  = 16;
  localparam int PW = 2 * W;      // full product
  localparam int SW = 2 * W + 2;  // sum of three products

  // Opcodes.
  localparam logic [2:0] OP_SUB   = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_DOT   = 3'd2;
  localparam logic [2:0] OP_CROSS = 3'd3;
  localparam logic [2:0] OP_SCALE = 3'd4;
  localparam logic [2:0] OP_LEN   = 3'd5;
  localparam logic [2:0] OP_NORM  = 3'd6;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  // Rounding constant: one half LSB of the result.
  localparam logic [SW-1:0] RND_HALF = {{(SW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};

  typedef struct packed {
    logic [2:0]          opcode;
    logic signed [W-1:0] a_x;
    logic signed [W-1:0] a_y;
    logic signed [W-1:0] a_z;
    logic signed [W-1:0] b_x;
    logic signed [W-1:0] b_y;
    logic signed [W-1:0] b_z;
    logic signed [W-1:0] scalar_in;
  } va_in_t;

  typedef struct packed {
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [W-1:0] r_z;
    logic [1:0]          status;
  } va_out_t;

  // Beat handed from the arithmetic front end to the square-root pipeline.
  typedef struct packed {
    logic [2:0]          opcode;
    va_out_t             res;
    logic signed [W-1:0] a_x;
    logic signed [W-1:0] a_y;
    logic signed [W-1:0] a_z;
    logic [PW-1:0]       sq;
  } va_mid_t;

  // Clamp a wide signed value to the word range; the MSB flags a clamp.
  function automatic logic [W:0] sat_word(input logic signed [SW-1:0] v);
    logic [W:0] r;
    if (v[SW-1:W-1] == {(SW - W + 1){1'b0}} || v[SW-1:W-1] == {(SW - W + 1){1'b1}}) begin
      r = {1'b0, v[W-1:0]};
    end else if (v[SW-1]) begin
      r = {1'b1, 1'b1, {(W - 1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(W - 1){1'b1}}};
    end
    return r;
  endfunction

  // Round half up and drop the fraction bits of a product.
  function automatic logic signed [SW-1:0] round_q(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = v + $signed(RND_HALF);
    return t >>> F;
  endfunction

endpackage

FILE: design/vector3_alu.sv
// ----------------------------------------------------------------------------
// vector3_alu
// Fixed-point Q16.16 3-D vector ALU: add, subtract, dot, cross, scale,
// length and normalize, with saturation and a status code per result.
// ----------------------------------------------------------------------------
// The ALU takes one beat per clock unless stalled and returns one result beat
// per input beat, in order, with the same latency for every opcode: three
// arithmetic stages (multiply, sum, round and clamp), 32 square-root stages
// that produce one root bit each, one length-rounding stage, 17 divider
// stages that produce one quotient bit each, and the output register. The
// square root and the divider set that latency. A stall on the result side
// freezes the whole pipeline and is passed straight back to the input side,
// so nothing is dropped or repeated; empty slots travel as bubbles.
module vector3_alu
  import va_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  va_in_t  in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output va_out_t out_data
);

  logic          adv;
  logic          mid_valid;
  va_mid_t       mid_data;
  logic          sq_valid;
  va_mid_t       sq_data;
  logic [W-1:0]  sq_root;
  logic [W+1:0]  sq_rem;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  va_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .mid_valid (mid_valid),
    .mid_data  (mid_data)
  );

  va_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (mid_valid),
    .in_data   (mid_data),
    .out_valid (sq_valid),
    .out_data  (sq_data),
    .out_root  (sq_root),
    .out_rem   (sq_rem)
  );

  va_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sq_valid),
    .in_data   (sq_data),
    .in_root   (sq_root),
    .in_rem    (sq_rem),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: design/va_front.sv
// ----------------------------------------------------------------------------
// va_front
// Three-stage arithmetic front end: operand select and multiply, product
// sums, then rounding and saturation of the direct results.
// ----------------------------------------------------------------------------
module va_front
  import va_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    in_valid,
  input  va_in_t  in_data,
  output logic    mid_valid,
  output va_mid_t mid_data
);

  logic signed [W-1:0]  a_in [3];
  logic signed [W-1:0]  b_in [3];
  logic signed [W-1:0]  ma [6];
  logic signed [W-1:0]  mb [6];

  logic                 v1_r;
  logic [2:0]           op1_r;
  logic signed [W-1:0]  a1_r [3];
  logic signed [W:0]    as1_r [3];
  logic signed [PW-1:0] p1_r [6];

  logic                 v2_r;
  logic [2:0]           op2_r;
  logic signed [W-1:0]  a2_r [3];
  logic signed [SW-1:0] s2_r [3];
  logic [PW-1:0]        sq2_r;

  logic signed [SW-1:0] s_nxt [3];
  logic signed [SW-1:0] sum3;
  logic                 v3_r;
  va_mid_t              mid_r;
  va_mid_t              mid_nxt;

  assign a_in[0] = in_data.a_x;
  assign a_in[1] = in_data.a_y;
  assign a_in[2] = in_data.a_z;
  assign b_in[0] = in_data.b_x;
  assign b_in[1] = in_data.b_y;
  assign b_in[2] = in_data.b_z;

  // Multiplier operand selection by opcode.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    unique case (in_data.opcode) inside
      OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = a_in[i];
          mb[i] = b_in[i];
        end
      end
      OP_CROSS: begin
        ma[0] = a_in[1]; mb[0] = b_in[2];
        ma[1] = a_in[2]; mb[1] = b_in[1];
        ma[2] = a_in[2]; mb[2] = b_in[0];
        ma[3] = a_in[0]; mb[3] = b_in[2];
        ma[4] = a_in[0]; mb[4] = b_in[1];
        ma[5] = a_in[1]; mb[5] = b_in[0];
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = a_in[i];
          mb[i] = in_data.scalar_in;
        end
      end
      OP_LEN, OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = a_in[i];
          mb[i] = a_in[i];
        end
      end
      default: begin
      end
    endcase
  end

  // Stage 1: products and component sums or differences.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= in_data.opcode;
      for (int i = 0; i < 3; i++) begin
        a1_r[i] <= a_in[i];
        if (in_data.opcode == OP_SUB) begin
          as1_r[i] <= {a_in[i][W-1], a_in[i]} - {b_in[i][W-1], b_in[i]};
        end else begin
          as1_r[i] <= {a_in[i][W-1], a_in[i]} + {b_in[i][W-1], b_in[i]};
        end
      end
      for (int i = 0; i < 6; i++) begin
        p1_r[i] <= ma[i] * mb[i];
      end
    end
  end

  // Stage 2: exact sums and differences of the products.
  assign sum3 = SW'(p1_r[0]) + SW'(p1_r[1]) + SW'(p1_r[2]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_nxt[i] = '0;
    end
    case (op1_r) inside
      OP_SUB, OP_ADD: begin
        for (int i = 0; i < 3; i++) begin
          s_nxt[i] = SW'(as1_r[i]);
        end
      end
      OP_DOT: begin
        s_nxt[0] = sum3;
      end
      OP_CROSS: begin
        s_nxt[0] = SW'(p1_r[0]) - SW'(p1_r[1]);
        s_nxt[1] = SW'(p1_r[2]) - SW'(p1_r[3]);
        s_nxt[2] = SW'(p1_r[4]) - SW'(p1_r[5]);
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          s_nxt[i] = SW'(p1_r[i]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op2_r <= op1_r;
      sq2_r <= sum3[PW-1:0];
      for (int i = 0; i < 3; i++) begin
        a2_r[i] <= a1_r[i];
        s2_r[i] <= s_nxt[i];
      end
    end
  end

  // Stage 3: round the product results and clamp every component.
  always_comb begin
    logic          rnd;
    logic [W:0]    c [3];
    rnd = (op2_r == OP_DOT) || (op2_r == OP_CROSS) || (op2_r == OP_SCALE);
    for (int i = 0; i < 3; i++) begin
      c[i] = sat_word(rnd ? round_q(s2_r[i]) : s2_r[i]);
    end
    mid_nxt.opcode     = op2_r;
    mid_nxt.res.r_x    = c[0][W-1:0];
    mid_nxt.res.r_y    = c[1][W-1:0];
    mid_nxt.res.r_z    = c[2][W-1:0];
    mid_nxt.res.status = (c[0][W] || c[1][W] || c[2][W]) ? ST_SAT : ST_OK;
    mid_nxt.a_x        = a2_r[0];
    mid_nxt.a_y        = a2_r[1];
    mid_nxt.a_z        = a2_r[2];
    mid_nxt.sq         = sq2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid_valid = v3_r;
  assign mid_data  = mid_r;

endmodule

FILE: design/va_sqrt.sv
// ----------------------------------------------------------------------------
// va_sqrt
// Pipelined restoring square root of the sum of squares, one root bit per
// stage, most significant bit first.
// ----------------------------------------------------------------------------
module va_sqrt
  import va_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  va_mid_t       in_data,
  output logic          out_valid,
  output va_mid_t       out_data,
  output logic [W-1:0]  out_root,
  output logic [W+1:0]  out_rem
);

  logic          v_r    [W];
  va_mid_t       d_r    [W];
  logic [W-1:0]  root_r [W];
  logic [W+1:0]  rem_r  [W];

  for (genvar g = 0; g < W; g++) begin : g_stage
    localparam int K = W - 1 - g;

    logic          v_prev;
    va_mid_t       d_prev;
    logic [W-1:0]  root_prev;
    logic [W+1:0]  rem_prev;
    logic [W+1:0]  rem_sh;
    logic [W+1:0]  trial;
    logic          take;

    if (g == 0) begin : g_first
      assign v_prev    = in_valid;
      assign d_prev    = in_data;
      assign root_prev = '0;
      assign rem_prev  = '0;
    end else begin : g_next
      assign v_prev    = v_r[g-1];
      assign d_prev    = d_r[g-1];
      assign root_prev = root_r[g-1];
      assign rem_prev  = rem_r[g-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_sh = {rem_prev[W-1:0], d_prev.sq[2*K+1 -: 2]};
    assign trial  = {root_prev, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (adv) begin
        v_r[g] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_r[g]    <= d_prev;
        root_r[g] <= {root_prev[W-2:0], take};
        rem_r[g]  <= take ? (rem_sh - trial) : rem_sh;
      end
    end
  end

  assign out_valid = v_r[W-1];
  assign out_data  = d_r[W-1];
  assign out_root  = root_r[W-1];
  assign out_rem   = rem_r[W-1];

endmodule

FILE: design/va_norm.sv
// ----------------------------------------------------------------------------
// va_norm
// Length rounding, pipelined three-lane restoring divider for normalize, and
// the output register that merges all results.
// ----------------------------------------------------------------------------
module va_norm
  import va_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  va_mid_t       in_data,
  input  logic [W-1:0]  in_root,
  input  logic [W+1:0]  in_rem,
  output logic          out_valid,
  output va_out_t       out_data
);

  localparam int NS = F + 1;  // quotient bits

  // Length stage.
  logic          len_nxt_gt;
  logic [W-1:0]  len_nxt;
  va_out_t       lres_nxt;
  logic signed [W-1:0] a_in [3];
  logic [W-1:0]  abs_nxt [3];

  logic          lv_r;
  logic [2:0]    lop_r;
  va_out_t       lres_r;
  logic [W-1:0]  len_r;
  logic          lneg_r  [3];
  logic          labs0_r [3];
  logic [W:0]    lrem_r  [3];

  // Divider stages.
  logic          dv_r   [NS];
  logic [2:0]    dop_r  [NS];
  va_out_t       dres_r [NS];
  logic [W-1:0]  dlen_r [NS];
  logic          dneg_r [NS][3];
  logic [W:0]    drem_r [NS][3];
  logic [F:0]    dq_r   [NS][3];

  logic          ov_r;
  va_out_t       out_r;
  va_out_t       out_nxt;

  assign a_in[0] = in_data.a_x;
  assign a_in[1] = in_data.a_y;
  assign a_in[2] = in_data.a_z;

  // Round the root to nearest and build the length result.
  assign len_nxt_gt = (in_rem > {2'b00, in_root});
  assign len_nxt    = in_root + W'(len_nxt_gt);

  always_comb begin
    lres_nxt = in_data.res;
    if (in_data.opcode == OP_LEN) begin
      lres_nxt.r_x    = len_nxt[W-1] ? {1'b0, {(W - 1){1'b1}}} : len_nxt;
      lres_nxt.r_y    = '0;
      lres_nxt.r_z    = '0;
      lres_nxt.status = len_nxt[W-1] ? ST_SAT : ST_OK;
    end else if (in_data.opcode == OP_NORM && len_nxt == '0) begin
      lres_nxt.r_x    = '0;
      lres_nxt.r_y    = '0;
      lres_nxt.r_z    = '0;
      lres_nxt.status = ST_ZERO;
    end
    for (int i = 0; i < 3; i++) begin
      abs_nxt[i] = a_in[i][W-1] ? (~a_in[i] + W'(1)) : a_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= 1'b0;
    end else if (adv) begin
      lv_r <= in_valid;
    end
  end

  // The divider's first partial remainder is the magnitude without its LSB.
  always_ff @(posedge clk) begin
    if (adv) begin
      lop_r  <= in_data.opcode;
      lres_r <= lres_nxt;
      len_r  <= len_nxt;
      for (int i = 0; i < 3; i++) begin
        lneg_r[i]  <= a_in[i][W-1];
        labs0_r[i] <= abs_nxt[i][0];
        lrem_r[i]  <= {2'b00, abs_nxt[i][W-1:1]};
      end
    end
  end

  // One quotient bit per stage in each lane.
  for (genvar j = 0; j < NS; j++) begin : g_div
    logic          v_prev;
    logic [2:0]    op_prev;
    va_out_t       res_prev;
    logic [W-1:0]  len_prev;
    logic          neg_prev [3];
    logic          bit_in   [3];
    logic [W:0]    rem_prev [3];
    logic [F:0]    q_prev   [3];
    logic [W:0]    rem_nxt  [3];
    logic [F:0]    q_nxt    [3];

    if (j == 0) begin : g_first
      always_comb begin
        v_prev   = lv_r;
        op_prev  = lop_r;
        res_prev = lres_r;
        len_prev = len_r;
        for (int i = 0; i < 3; i++) begin
          neg_prev[i] = lneg_r[i];
          bit_in[i]   = labs0_r[i];
          rem_prev[i] = lrem_r[i];
          q_prev[i]   = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        v_prev   = dv_r[j-1];
        op_prev  = dop_r[j-1];
        res_prev = dres_r[j-1];
        len_prev = dlen_r[j-1];
        for (int i = 0; i < 3; i++) begin
          neg_prev[i] = dneg_r[j-1][i];
          bit_in[i]   = 1'b0;
          rem_prev[i] = drem_r[j-1][i];
          q_prev[i]   = dq_r[j-1][i];
        end
      end
    end

    always_comb begin
      logic [W:0] r2;
      logic       ge;
      for (int i = 0; i < 3; i++) begin
        r2         = {rem_prev[i][W-1:0], bit_in[i]};
        ge         = (r2 >= {1'b0, len_prev});
        rem_nxt[i] = ge ? (r2 - {1'b0, len_prev}) : r2;
        q_nxt[i]   = {q_prev[i][F-1:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (adv) begin
        dv_r[j] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dop_r[j]  <= op_prev;
        dres_r[j] <= res_prev;
        dlen_r[j] <= len_prev;
        for (int i = 0; i < 3; i++) begin
          dneg_r[j][i] <= neg_prev[i];
          drem_r[j][i] <= rem_nxt[i];
          dq_r[j][i]   <= q_nxt[i];
        end
      end
    end
  end

  // Round the quotients half up, restore the sign and pick the result.
  always_comb begin
    logic         up;
    logic [F+1:0] q2;
    logic [W-1:0] mag;
    logic [W-1:0] c [3];
    for (int i = 0; i < 3; i++) begin
      up   = ({drem_r[NS-1][i][W-1:0], 1'b0} >= {1'b0, dlen_r[NS-1]});
      q2   = (F + 2)'(dq_r[NS-1][i]) + (F + 2)'(up);
      mag  = W'(q2);
      c[i] = dneg_r[NS-1][i] ? (~mag + W'(1)) : mag;
    end
    out_nxt = dres_r[NS-1];
    if (dop_r[NS-1] == OP_NORM && dres_r[NS-1].status != ST_ZERO) begin
      out_nxt.r_x    = c[0];
      out_nxt.r_y    = c[1];
      out_nxt.r_z    = c[2];
      out_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dv_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule
